@@ rtl/core/psema_pkg.sv @@
// Shared types and constants of the pressure scale, EMA and stability block.
`timescale 1ns / 1ps
`default_nettype none

package psema_pkg;

    // Pressure range, 21-bit two's complement in 1/256 mmHg
    localparam int                 P_W   = 21;
    localparam logic signed [20:0] P_MAX = 21'sh0FFFFF;
    localparam logic signed [20:0] P_MIN = 21'sh100000;

    // Fixed-point formats
    localparam int GAIN_W     = 24;
    localparam int GAIN_SHIFT = 24;
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam int BAND_W     = 20;
    localparam int NEED_W     = 4;
    localparam int OPB_W      = 25;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    localparam t_cfg_addr REG_ZERO_OFFSET   = 3'd0;
    localparam t_cfg_addr REG_GAIN          = 3'd1;
    localparam t_cfg_addr REG_INVERT        = 3'd2;
    localparam t_cfg_addr REG_ALPHA         = 3'd3;
    localparam t_cfg_addr REG_STABLE_BAND   = 3'd4;
    localparam t_cfg_addr REG_STABLE_NEEDED = 3'd5;

    // Configuration reset values
    localparam logic [GAIN_W-1:0]  GAIN_RST   = 24'd715886;
    localparam logic [ALPHA_W-1:0] ALPHA_RST  = 17'd9830;
    localparam logic [BAND_W-1:0]  BAND_RST   = 20'd563;
    localparam logic [NEED_W-1:0]  NEEDED_RST = 4'd4;

    // Sequencer state codes
    typedef logic [2:0] t_state;
    localparam t_state S_IDLE  = 3'd0;
    localparam t_state S_MUL_G = 3'd1;
    localparam t_state S_SCALE = 3'd2;
    localparam t_state S_MUL_A = 3'd3;
    localparam t_state S_MUL_B = 3'd4;
    localparam t_state S_ACC   = 3'd5;
    localparam t_state S_DONE  = 3'd6;

endpackage

`default_nettype wire

@@ rtl/core/psema_in_if.sv @@
// Input channel: one raw bridge ADC sample per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface psema_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

@@ rtl/core/psema_out_if.sv @@
// Output channel: instant pressure, filtered pressure and stable flag per transfer.
`timescale 1ns / 1ps
`default_nettype none

interface psema_out_if;
    logic               valid;
    logic               ready;
    logic signed [20:0] pressure_now;
    logic signed [20:0] pressure_filtered;
    logic               stable;

    modport source (output valid, output pressure_now, output pressure_filtered,
                    output stable, input ready);
    modport sink   (input valid, input pressure_now, input pressure_filtered,
                    input stable, output ready);
endinterface

`default_nettype wire

@@ rtl/core/psema_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module psema_mul #(
    parameter int A_W = 25,
    parameter int B_W = 25
) (
    input  wire                      i_clk,
    input  wire signed [A_W-1:0]     i_op_a,
    input  wire signed [B_W-1:0]     i_op_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;

    // Register every product; the sequencer picks it up in the cycle after
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ rtl/core/pressure_scale_ema_stability.sv @@
// Top level: offset, gain scaling, inversion, EMA filter and stability counter.
// The first sample after reset passes the states MUL_G, SCALE and DONE, every later
// one MUL_G, SCALE, MUL_A, MUL_B, ACC and DONE (one shared multiplier used three times).
// DONE waits while the output register is full and not taken. The input is ready only
// while the sequencer is idle, so a new sample is taken only after the last leaves DONE.
// Reset (synchronous, active low) loads the register defaults, clears the filter
// state and arms the first-sample load; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module pressure_scale_ema_stability
    import psema_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 4
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    psema_in_if.sink                 i_in,
    psema_out_if.source              o_out,
    input  wire                      i_cfg_we,
    input  wire [CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire [((SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W)-1:0] i_cfg_data
);

    localparam int DW  = SAMPLE_BITS + 1;
    localparam int PW  = DW + OPB_W;
    localparam int CW  = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [PW-1:0]  ROUND_HALF = PW'(32768);

    // Configuration registers
    logic signed [SAMPLE_BITS-1:0] r_zero_offset;
    logic [GAIN_W-1:0]             r_gain;
    logic                          r_invert;
    logic [ALPHA_W-1:0]            r_alpha;
    logic [BAND_W-1:0]             r_band;
    logic [NEED_W-1:0]             r_needed;

    // Sequencer and datapath registers
    t_state                r_state, n_state;
    logic signed [DW-1:0]  r_delta;
    logic signed [P_W-1:0] r_now;
    logic signed [P_W-1:0] r_filt;
    logic signed [P_W-1:0] r_prev;
    logic [COUNT_BITS-1:0] r_count;
    logic                  r_first;
    logic signed [PW-1:0]  r_acc;

    // Output register
    logic                  r_out_valid;
    logic signed [P_W-1:0] r_out_now;
    logic signed [P_W-1:0] r_out_filt;
    logic                  r_out_stable;

    // Shared multiplier
    logic signed [DW-1:0]    w_op_a;
    logic signed [OPB_W-1:0] w_op_b;
    logic signed [PW-1:0]    w_prod;

    logic [ALPHA_W-1:0]    w_alpha;
    logic [ALPHA_W-1:0]    w_beta;
    logic signed [PW-1:0]  w_shift;
    logic signed [P_W-1:0] w_sat;
    logic signed [P_W-1:0] w_now;
    logic signed [PW-1:0]  w_sum;
    logic signed [P_W+1:0] w_diff;
    logic [P_W+1:0]        w_abs;
    logic [COUNT_BITS-1:0] w_count;
    logic                  w_stable;
    logic                  w_in_xfer;
    logic                  w_load;

    assign w_in_xfer = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // Clamp alpha to one and form its complement
    assign w_alpha = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;
    assign w_beta  = ONE_Q16 - w_alpha;

    // Select multiplier operands by step
    always_comb begin
        w_op_a = r_delta;
        w_op_b = $signed({1'b0, r_gain});
        case (r_state)
            S_MUL_A: begin
                w_op_a = DW'(r_now);
                w_op_b = $signed({{(OPB_W - ALPHA_W){1'b0}}, w_alpha});
            end
            S_MUL_B: begin
                w_op_a = DW'(r_filt);
                w_op_b = $signed({{(OPB_W - ALPHA_W){1'b0}}, w_beta});
            end
            default: begin
                w_op_a = r_delta;
                w_op_b = $signed({1'b0, r_gain});
            end
        endcase
    end

    psema_mul #(
        .A_W (DW),
        .B_W (OPB_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    // Scale: floor shift, saturate, optional negate
    assign w_shift = w_prod >>> GAIN_SHIFT;
    always_comb begin
        if (w_shift > P_MAX) begin
            w_sat = P_MAX;
        end else if (w_shift < P_MIN) begin
            w_sat = P_MIN;
        end else begin
            w_sat = w_shift[P_W-1:0];
        end
        if (!r_invert) begin
            w_now = w_sat;
        end else if (w_sat == P_MIN) begin
            w_now = P_MAX;
        end else begin
            w_now = -w_sat;
        end
    end

    // EMA sum with round to nearest
    assign w_sum = r_acc + w_prod + ROUND_HALF;

    // Change against previous filtered value and steady count
    assign w_diff = {r_filt[P_W-1], r_filt[P_W-1], r_filt}
                  - {r_prev[P_W-1], r_prev[P_W-1], r_prev};
    assign w_abs  = w_diff[P_W+1] ? (P_W+2)'(-w_diff) : w_diff;
    always_comb begin
        if (w_abs <= {3'b000, r_band}) begin
            w_count = (r_count == CNT_MAX) ? r_count : r_count + 1'b1;
        end else begin
            w_count = '0;
        end
    end
    assign w_stable = (CW'(w_count) >= CW'(r_needed));

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_MUL_G;
            S_MUL_G: n_state = S_SCALE;
            S_SCALE: n_state = r_first ? S_DONE : S_MUL_A;
            S_MUL_A: n_state = S_MUL_B;
            S_MUL_B: n_state = S_ACC;
            S_ACC:   n_state = S_DONE;
            S_DONE:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_first       <= 1'b1;
            r_filt        <= '0;
            r_prev        <= '0;
            r_count       <= '0;
            r_out_valid   <= 1'b0;
            r_zero_offset <= '0;
            r_gain        <= GAIN_RST;
            r_invert      <= 1'b1;
            r_alpha       <= ALPHA_RST;
            r_band        <= BAND_RST;
            r_needed      <= NEEDED_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ZERO_OFFSET:   r_zero_offset <= $signed(i_cfg_data[SAMPLE_BITS-1:0]);
                    REG_GAIN:          r_gain        <= i_cfg_data[GAIN_W-1:0];
                    REG_INVERT:        r_invert      <= i_cfg_data[0];
                    REG_ALPHA:         r_alpha       <= i_cfg_data[ALPHA_W-1:0];
                    REG_STABLE_BAND:   r_band        <= i_cfg_data[BAND_W-1:0];
                    REG_STABLE_NEEDED: r_needed      <= i_cfg_data[NEED_W-1:0];
                    default: ;
                endcase
            end
            // Load filter directly on the first sample, else take the EMA result
            if (r_state == S_SCALE && r_first) begin
                r_filt  <= w_now;
                r_first <= 1'b0;
            end
            if (r_state == S_ACC) begin
                r_filt <= w_sum[ALPHA_FRAC + P_W - 1:ALPHA_FRAC];
            end
            if (w_load) begin
                r_prev  <= r_filt;
                r_count <= w_count;
            end
            // Hold output until its transfer
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_delta <= $signed({i_in.raw_sample[SAMPLE_BITS-1], i_in.raw_sample})
                     - $signed({r_zero_offset[SAMPLE_BITS-1], r_zero_offset});
        end
        if (r_state == S_SCALE) begin
            r_now <= w_now;
        end
        if (r_state == S_MUL_B) begin
            r_acc <= w_prod;
        end
        if (w_load) begin
            r_out_now    <= r_now;
            r_out_filt   <= r_filt;
            r_out_stable <= w_stable;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.pressure_now      = r_out_now;
    assign o_out.pressure_filtered = r_out_filt;
    assign o_out.stable            = r_out_stable;

    // Checks
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> r_state == S_MUL_G)
        else $error("accepted sample did not start the multiply step");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_in.ready)
        else $error("input ready while a sample is in progress");

    a_first_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> r_filt == r_now)
        else $error("first sample did not load the filter");

    a_out_filt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> o_out.pressure_filtered == r_filt && r_prev == r_filt)
        else $error("output filtered value differs from filter state");

endmodule

`default_nettype wire

@@ tb/psema_pressure_check.sv @@
// Checker for the pressure scale, EMA and stability block: predicts each reading and compares.
`timescale 1ns / 1ps

module psema_pressure_check
    import psema_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COUNT_BITS  = 4,
    parameter int CFG_DATA_W  = 24
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    psema_in_if                  in_ch,
    psema_out_if                 out_ch,
    input  wire                  i_cfg_we,
    input  wire [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam longint PRESS_MAX  = 1048575;
    localparam longint PRESS_MIN  = -1048576;
    localparam longint ALPHA_ONE  = 65536;
    localparam int     STEADY_TOP = (1 << COUNT_BITS) - 1;
    localparam int     PRINT_CAP  = 50;

    typedef struct {
        logic signed [P_W-1:0] now;
        logic signed [P_W-1:0] filtered;
        logic                  stable;
    } t_reading;

    // Readings predicted for accepted samples, oldest first
    t_reading pending_readings[$];

    // Shadow of the configuration registers
    longint offset_cfg;
    longint gain_cfg;
    bit     invert_cfg;
    longint alpha_cfg;
    longint band_cfg;
    int     needed_cfg;

    // Shadow of the filter and stability state
    longint filtered_p;
    longint last_filtered_p;
    int     steady_run;
    bit     load_next;

    int fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        // Stay quiet after the first few dozen lines
        if (fail_count <= PRINT_CAP) begin
            $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic longint clamp_pressure(input longint v);
        if (v > PRESS_MAX) return PRESS_MAX;
        if (v < PRESS_MIN) return PRESS_MIN;
        return v;
    endfunction

    function automatic t_reading predict_reading(input logic signed [SAMPLE_BITS-1:0] raw);
        longint   delta;
        longint   prod;
        longint   now_p;
        longint   weight;
        longint   acc;
        longint   change;
        t_reading r;

        // Offset, gain and floor shift, then saturate and optionally negate
        delta = longint'(raw) - offset_cfg;
        prod  = delta * gain_cfg;
        now_p = clamp_pressure(prod >>> GAIN_SHIFT);
        if (invert_cfg) now_p = clamp_pressure(-now_p);

        // First sample after reset loads the filter, later ones blend in
        if (load_next) begin
            filtered_p = now_p;
            load_next  = 1'b0;
        end else begin
            weight     = (alpha_cfg > ALPHA_ONE) ? ALPHA_ONE : alpha_cfg;
            acc        = weight * now_p + (ALPHA_ONE - weight) * filtered_p;
            filtered_p = clamp_pressure((acc + 64'sd32768) >>> ALPHA_FRAC);
        end

        // Steady run counts small moves of the filtered value
        change = filtered_p - last_filtered_p;
        if (change < 0) change = -change;
        if (change <= band_cfg) begin
            if (steady_run < STEADY_TOP) steady_run++;
        end else begin
            steady_run = 0;
        end
        last_filtered_p = filtered_p;

        r.now      = now_p[P_W-1:0];
        r.filtered = filtered_p[P_W-1:0];
        r.stable   = (steady_run >= needed_cfg);
        return r;
    endfunction

    task automatic apply_write(input t_cfg_addr idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ZERO_OFFSET:   offset_cfg = longint'($signed(data[SAMPLE_BITS-1:0]));
            REG_GAIN:          gain_cfg   = longint'(data[GAIN_W-1:0]);
            REG_INVERT:        invert_cfg = data[0];
            REG_ALPHA:         alpha_cfg  = longint'(data[ALPHA_W-1:0]);
            REG_STABLE_BAND:   band_cfg   = longint'(data[BAND_W-1:0]);
            REG_STABLE_NEEDED: needed_cfg = int'(data[NEED_W-1:0]);
            default: ;
        endcase
    endtask

    // Track writes, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin : watch
        t_reading want;

        if (!i_rst_n) begin
            offset_cfg      = 0;
            gain_cfg        = longint'(GAIN_RST);
            invert_cfg      = 1'b1;
            alpha_cfg       = longint'(ALPHA_RST);
            band_cfg        = longint'(BAND_RST);
            needed_cfg      = int'(NEEDED_RST);
            filtered_p      = 0;
            last_filtered_p = 0;
            steady_run      = 0;
            load_next       = 1'b1;
            pending_readings.delete();
        end else begin
            if (i_cfg_we === 1'b1) apply_write(i_cfg_addr, i_cfg_data);

            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
                pending_readings.push_back(predict_reading(in_ch.raw_sample));
            end

            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                if (pending_readings.size() == 0) begin
                    report_mismatch("reading without sample", longint'(out_ch.pressure_now), 0);
                end else begin
                    want = pending_readings.pop_front();
                    if (out_ch.pressure_now !== want.now) begin
                        report_mismatch("pressure_now", longint'(out_ch.pressure_now),
                                        longint'(want.now));
                    end
                    if (out_ch.pressure_filtered !== want.filtered) begin
                        report_mismatch("pressure_filtered", longint'(out_ch.pressure_filtered),
                                        longint'(want.filtered));
                    end
                    if (out_ch.stable !== want.stable) begin
                        report_mismatch("stable", longint'(out_ch.stable), longint'(want.stable));
                    end
                end
            end
        end
        o_pending <= pending_readings.size();
    end

endmodule

@@ tb/tb_pressure_scale_ema_stability.sv @@
// Testbench top: clock, reset, register writes, sample stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_pressure_scale_ema_stability;
    import psema_pkg::*;

    localparam int     SAMPLE_BITS   = 24;
    localparam int     COUNT_BITS    = 4;
    localparam int     CFG_DATA_W    = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
    localparam int     SAMPLE_TARGET = 1750;
    localparam int     LONG_HOLD     = 300;
    localparam int     SETTLE_CYCLES = 12;
    // Watchdog limit, above the slowest run with worst gaps and stalls
    localparam longint CYCLE_LIMIT   = 1000000;
    localparam longint S_MAX         = 8388607;
    localparam longint S_MIN         = -8388608;
    localparam longint ALPHA_ONE_TB  = 65536;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_addr             cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    int     fail_count;
    int     pending;
    int     samples_sent  = 0;
    int     hold_requests = 0;
    int     hold_served   = 0;
    longint cycle_count   = 0;

    psema_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    psema_out_if out_ch ();

    pressure_scale_ema_stability #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    psema_pressure_check #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .CFG_DATA_W  (CFG_DATA_W)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint rand_sample();
        logic [SAMPLE_BITS-1:0] bits;
        bits = SAMPLE_BITS'($urandom());
        return longint'($signed(bits));
    endfunction

    function automatic longint clamp_sample(input longint v);
        if (v > S_MAX) return S_MAX;
        if (v < S_MIN) return S_MIN;
        return v;
    endfunction

    // Offer one sample after an idle gap and hold it until the transfer
    task automatic send_sample(input longint value, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.raw_sample <= value[SAMPLE_BITS-1:0];
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        samples_sent++;
    endtask

    // Stop offering and wait for every predicted reading to come back
    task automatic drain_readings();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input t_cfg_addr idx, input longint value);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic load_config(input longint offset, input longint gain, input longint inv,
                               input longint alpha, input longint band, input longint needed);
        drain_readings();
        write_reg(REG_ZERO_OFFSET, offset);
        write_reg(REG_GAIN, gain);
        write_reg(REG_INVERT, inv);
        write_reg(REG_ALPHA, alpha);
        write_reg(REG_STABLE_BAND, band);
        write_reg(REG_STABLE_NEEDED, needed);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        longint offset;
        longint gain;
        longint alpha;
        longint band;

        case ($urandom_range(0, 5))
            0:       offset = 0;
            1:       offset = S_MIN;
            2:       offset = S_MAX;
            3:       offset = longint'($urandom_range(0, 200000)) - 100000;
            default: offset = rand_sample();
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: gain = 715886 + longint'($urandom_range(0, 131072)) - 65536;
            4:          gain = 24'hFFFFFF;
            5:          gain = 0;
            default:    gain = longint'($urandom_range(0, 24'hFFFFFF));
        endcase
        case ($urandom_range(0, 7))
            0:       alpha = 0;
            1:       alpha = ALPHA_ONE_TB;
            2:       alpha = longint'($urandom_range(65537, 131071));
            default: alpha = longint'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 7))
            0:       band = 0;
            1:       band = 20'hFFFFF;
            2:       band = longint'($urandom_range(0, 20'hFFFFF));
            default: band = longint'($urandom_range(0, 4000));
        endcase
        load_config(offset, gain, longint'($urandom_range(0, 1)), alpha, band,
                    longint'($urandom_range(0, 15)));
    endtask

    // Mostly noisy plateaus with steps and spikes; some phases are pure noise
    task automatic run_phase(input int count, input bit no_idle);
        longint base;
        longint value;
        int     spread;
        int     r;
        bit     wild;

        base   = rand_sample();
        spread = $urandom_range(0, 200);
        wild   = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) base = rand_sample();
            if (wild || (r >= 4 && r < 10)) begin
                value = rand_sample();
            end else begin
                value = clamp_sample(base + longint'($urandom_range(0, 2 * spread))
                                     - longint'(spread));
            end
            send_sample(value, no_idle ? 0 : pick_gap());
        end
    endtask

    // Output side: random stalls, quiet stretches, and long hold-offs on request
    initial begin : receiver
        int gap;
        int quiet_left;

        quiet_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_requests != hold_served) begin
                hold_served++;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                if (quiet_left > 0) begin
                    quiet_left--;
                    gap = 0;
                end else begin
                    gap = pick_gap();
                    if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(50, 300);
                end
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int phase_idx;

        in_ch.valid      <= 1'b0;
        in_ch.raw_sample <= '0;
        cfg_we           <= 1'b0;
        cfg_addr         <= REG_ZERO_OFFSET;
        cfg_data         <= '0;
        i_rst_n          <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first sample loads the filter, field extremes, a plateau, then an alternating bit pattern
        send_sample(0, pick_gap());
        send_sample(S_MAX, pick_gap());
        send_sample(S_MIN, pick_gap());
        send_sample(-1, pick_gap());
        send_sample(1, pick_gap());
        repeat (4) send_sample(1000, pick_gap());
        send_sample(64'sh555555, pick_gap());

        // Full gain from the lowest offset: saturate high and fall to zero, alpha of one, zero band
        load_config(S_MIN, 24'hFFFFFF, 0, ALPHA_ONE_TB, 0, 1);
        send_sample(S_MAX, pick_gap());
        send_sample(S_MIN, pick_gap());
        send_sample(S_MIN, pick_gap());
        send_sample(S_MAX, pick_gap());

        // Most negative pressure inverted, frozen filter, widest band, largest count
        load_config(S_MAX, 24'hFFFFFF, 1, 0, 20'hFFFFF, 15);
        send_sample(S_MIN, pick_gap());
        send_sample(S_MAX, pick_gap());
        repeat (3) send_sample(rand_sample(), pick_gap());

        // Zero gain, alpha above one, stable needed zero
        load_config(0, 0, 0, 100000, 563, 0);
        send_sample(S_MAX, pick_gap());
        send_sample(S_MIN, pick_gap());

        load_config(12345, 715886, 1, 131071, 563, 4);
        repeat (3) send_sample(rand_sample(), pick_gap());

        // Random phases, each with fresh settings
        phase_idx = 0;
        while (samples_sent < SAMPLE_TARGET) begin
            random_config();
            if (phase_idx == 2 || phase_idx == 11) begin
                // Output held off while samples keep coming: input must stall
                hold_requests <= hold_requests + 1;
                run_phase(60, 1'b1);
            end else begin
                run_phase($urandom_range(20, 120), $urandom_range(0, 5) == 0);
            end
            phase_idx++;
        end

        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
